FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define SXFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked at every rising clk edge outside reset
`define SXFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sxfd_pkg.sv
// ----------------------------------------------------------------------------
// sxfd_pkg
// constants, codes and helpers of the sync byte deframer
// ----------------------------------------------------------------------------
`default_nettype none

package sxfd_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    typedef logic [7:0]       byte_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [1:0]       kind_t;
    typedef logic [1:0]       cfg_idx_t;

    localparam kind_t KIND_BALL        = 2'd0;
    localparam kind_t KIND_FIRST_GOAL  = 2'd1;
    localparam kind_t KIND_SECOND_GOAL = 2'd2;
    localparam kind_t KIND_NONE        = 2'd3;

    localparam cfg_idx_t REG_BALL_SYNC        = 2'd0;
    localparam cfg_idx_t REG_FIRST_GOAL_SYNC  = 2'd1;
    localparam cfg_idx_t REG_SECOND_GOAL_SYNC = 2'd2;

    localparam byte_t BALL_SYNC_RST        = 8'd65;
    localparam byte_t FIRST_GOAL_SYNC_RST  = 8'd66;
    localparam byte_t SECOND_GOAL_SYNC_RST = 8'd67;

    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // ball wins over first goal, first goal over second goal
    function automatic kind_t kind_of(input byte_t b, input byte_t ball,
                                      input byte_t goal1, input byte_t goal2);
        kind_t k;
        priority if (b == ball)  k = KIND_BALL;
        else if (b == goal1)     k = KIND_FIRST_GOAL;
        else if (b == goal2)     k = KIND_SECOND_GOAL;
        else                     k = KIND_NONE;
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sync_xor_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_xor_frame_deframer_unit
// serial byte deframer: sync hunt, 8-byte frame, xor checksum, field decode
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received byte per item in tdata[7:0]
//   cfg writes the three sync bytes (index 0 ball, 1 first goal, 2 second
//   goal); cfg_ready is always high, write only while the block is idle
//   m_axis gives one decoded item per complete frame whose byte zero still
//   matches a sync register; frames that match none are dropped
//   an item is taken into an input register on acceptance and processed
//   once the output register is empty or being read; the decoded item is
//   in the output register at the edge after its checksum byte is processed
//   throughput is one byte per cycle while m_axis does not stall, set by
//   the single input register feeding the frame state and the output register
//   when m_axis stalls with a result held, the input register keeps its
//   byte and s_axis_tready drops once that register is full
//   reset puts the block back to hunting, clears both valid flags and loads
//   the sync registers with 65, 66 and 67
`default_nettype none

`include "assert_macros.svh"

module sync_xor_frame_deframer_unit
    import sxfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // target_detected, angle_centideg,
                                             // distance_value, size_value, zero pad
    output logic [2:0]       m_axis_tuser,   // frame_status, frame_kind

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    byte_t ball_sync_reg;
    byte_t goal1_sync_reg;
    byte_t goal2_sync_reg;

    logic  in_valid_reg;
    byte_t in_byte_reg;

    logic  in_frame_reg, in_frame_next;
    pos_t  pos_reg, pos_next;
    byte_t xor_reg, xor_next;
    byte_t frame_bytes_reg [0:FRAME_LEN-2];

    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg;
    kind_t              out_kind_reg;
    logic               out_target_reg;
    logic signed [15:0] out_angle_reg;
    logic [15:0]        out_dist_reg;
    byte_t              out_size_reg;

    logic  advance;
    logic  accept;
    logic  byte_wr;
    pos_t  byte_idx;
    logic  load_out;
    kind_t kind_in;
    kind_t kind_hdr;

    assign cfg_ready = 1'b1;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign kind_in  = kind_of(in_byte_reg, ball_sync_reg, goal1_sync_reg, goal2_sync_reg);
    assign kind_hdr = kind_of(frame_bytes_reg[0], ball_sync_reg, goal1_sync_reg,
                              goal2_sync_reg);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        byte_wr       = 1'b0;
        byte_idx      = pos_reg;
        load_out      = 1'b0;
        if (advance)
        begin
            if (!in_frame_reg)
            begin
                if (kind_in != KIND_NONE)
                begin
                    byte_wr       = 1'b1;
                    byte_idx      = '0;
                    xor_next      = in_byte_reg;
                    pos_next      = pos_t'(1);
                    in_frame_next = 1'b1;
                end
            end
            else if (pos_reg != LAST_POS)
            begin
                byte_wr  = 1'b1;
                xor_next = xor_reg ^ in_byte_reg;
                pos_next = pos_reg + pos_t'(1);
            end
            else
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                xor_next      = '0;
                load_out      = (kind_hdr != KIND_NONE);
            end
        end
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ball_sync_reg  <= BALL_SYNC_RST;
            goal1_sync_reg <= FIRST_GOAL_SYNC_RST;
            goal2_sync_reg <= SECOND_GOAL_SYNC_RST;
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            pos_reg        <= '0;
            xor_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BALL_SYNC:        ball_sync_reg  <= cfg_data;
                    REG_FIRST_GOAL_SYNC:  goal1_sync_reg <= cfg_data;
                    REG_SECOND_GOAL_SYNC: goal2_sync_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            xor_reg       <= xor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= s_axis_tdata;
        if (byte_wr)
            frame_bytes_reg[byte_idx] <= in_byte_reg;
        if (load_out)
        begin
            out_status_reg <= (xor_reg == in_byte_reg) ? STATUS_GOOD : STATUS_MISMATCH;
            out_kind_reg   <= kind_hdr;
            out_target_reg <= (frame_bytes_reg[1] != 8'd0);
            out_angle_reg  <= {frame_bytes_reg[2], frame_bytes_reg[3]};
            out_dist_reg   <= {frame_bytes_reg[4], frame_bytes_reg[5]};
            out_size_reg   <= frame_bytes_reg[6];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_kind_reg, out_status_reg};
    assign m_axis_tdata  = {7'd0, out_size_reg, out_dist_reg, out_angle_reg,
                            out_target_reg};

    `SXFD_ASSERT(a_pos_in_frame, in_frame_reg == (pos_reg != '0), "position out of step with frame flag")
    `SXFD_ASSERT_IMP(a_out_from_checksum, $rose(out_valid_reg), $past(in_frame_reg) && ($past(pos_reg) == LAST_POS), "result without checksum byte")
    `SXFD_ASSERT_IMP(a_out_kind_valid, out_valid_reg, out_kind_reg != KIND_NONE, "result with no matching kind")
    `SXFD_ASSERT_IMP(a_xor_cleared, $fell(in_frame_reg), xor_reg == '0, "checksum not cleared after frame")

endmodule

`default_nettype wire
